[hdl/lcd4_pkg.sv]
`timescale 1ns / 1ps

package lcd4_pkg;

    localparam int HOLD_BITS_DEFAULT   = 20;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int US_W   = 20;
    localparam int SUM_W  = US_W + 1;
    localparam int STEP_W = 4;

    localparam logic [US_W-1:0] FIXED_WAIT_US = 20'd1000;

    localparam logic [2:0] REQ_COMMAND = 3'd0;
    localparam logic [2:0] REQ_DATA    = 3'd1;
    localparam logic [2:0] REQ_GOTO    = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_INIT    = 3'd4;
    localparam logic [2:0] REQ_GLYPH   = 3'd5;

    localparam logic [2:0] CFG_ENABLE_PULSE = 3'd0;
    localparam logic [2:0] CFG_NIBBLE_GAP   = 3'd1;
    localparam logic [2:0] CFG_CURSOR_WAIT  = 3'd2;
    localparam logic [2:0] CFG_COMMAND_WAIT = 3'd3;
    localparam logic [2:0] CFG_CLEAR_WAIT   = 3'd4;
    localparam logic [2:0] CFG_STARTUP_WAIT = 3'd5;

    localparam logic [7:0] CMD_INIT_A     = 8'h33;
    localparam logic [7:0] CMD_INIT_B     = 8'h32;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0E;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_CGRAM      = 8'h40;

    localparam logic [1:0] PH_HIGH_EN  = 2'd0;
    localparam logic [1:0] PH_HIGH_LOW = 2'd1;
    localparam logic [1:0] PH_LOW_EN   = 2'd2;
    localparam logic [1:0] PH_LOW_LOW  = 2'd3;

    typedef enum logic [2:0] {
        EXTRA_NONE,
        EXTRA_CURSOR,
        EXTRA_COMMAND,
        EXTRA_CLEAR,
        EXTRA_CMD_FIXED,
        EXTRA_FIXED
    } extra_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_EXPAND
    } front_state_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        extra_t     extra;
        logic       startup;
        logic       last;
    } byte_op_t;

    typedef struct packed {
        logic [US_W-1:0] enable_pulse;
        logic [US_W-1:0] nibble_gap;
        logic [US_W-1:0] cursor_wait;
        logic [US_W-1:0] command_wait;
        logic [US_W-1:0] clear_wait;
        logic [US_W-1:0] startup_wait;
    } cfg_t;

    function automatic logic [7:0] row_base(input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0: b = 8'h80;
            2'd1: b = 8'hC0;
            2'd2: b = 8'h94;
            default: b = 8'hD4;
        endcase
        return b;
    endfunction

endpackage

[hdl/lcd4_front.sv]
`timescale 1ns / 1ps

module lcd4_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  accept,
    input  logic [2:0]            req_type,
    input  logic [7:0]            byte_value,
    input  logic [4:0]            column,
    input  logic [2:0]            row,
    input  logic [2:0]            glyph_slot,
    input  logic [63:0]           glyph_rows,
    input  logic                  q_full,
    output logic                  push,
    output lcd4_pkg::byte_op_t    op,
    output logic                  active
);

    lcd4_pkg::front_state_t state_reg, state_next;
    logic [lcd4_pkg::STEP_W-1:0] step_reg, step_next;
    logic [2:0]  type_reg, type_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  addr_reg, addr_next;
    logic [2:0]  slot_reg, slot_next;
    logic [63:0] rows_reg, rows_next;
    logic [2:0]  row_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcd4_pkg::FRONT_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        byte_reg <= byte_next;
        addr_reg <= addr_next;
        slot_reg <= slot_next;
        rows_reg <= rows_next;
    end

    assign row_idx = step_reg[2:0] - 3'd1;

    always_comb
    begin
        op         = '0;
        op.extra   = lcd4_pkg::EXTRA_NONE;
        unique case (type_reg)
            lcd4_pkg::REQ_COMMAND:
            begin
                op.value = byte_reg;
                op.last  = 1'b1;
            end
            lcd4_pkg::REQ_DATA:
            begin
                op.rs    = 1'b1;
                op.value = byte_reg;
                op.last  = 1'b1;
            end
            lcd4_pkg::REQ_GOTO:
            begin
                op.value = addr_reg;
                op.extra = lcd4_pkg::EXTRA_CURSOR;
                op.last  = 1'b1;
            end
            lcd4_pkg::REQ_CLEAR:
            begin
                op.value = lcd4_pkg::CMD_CLEAR;
                op.extra = lcd4_pkg::EXTRA_CLEAR;
                op.last  = 1'b1;
            end
            lcd4_pkg::REQ_INIT:
            begin
                op.extra = lcd4_pkg::EXTRA_COMMAND;
                unique case (step_reg)
                    4'd0: op.startup = 1'b1;
                    4'd1: op.value = lcd4_pkg::CMD_INIT_A;
                    4'd2: op.value = lcd4_pkg::CMD_INIT_B;
                    4'd3: op.value = lcd4_pkg::CMD_FUNC_SET;
                    4'd4: op.value = lcd4_pkg::CMD_DISPLAY_ON;
                    4'd5:
                    begin
                        op.value = lcd4_pkg::CMD_CLEAR;
                        op.extra = lcd4_pkg::EXTRA_CLEAR;
                    end
                    default:
                    begin
                        op.value = lcd4_pkg::CMD_ENTRY_MODE;
                        op.extra = lcd4_pkg::EXTRA_CMD_FIXED;
                        op.last  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                if (step_reg == '0)
                begin
                    op.value = lcd4_pkg::CMD_CGRAM | {2'b00, slot_reg, 3'b000};
                end
                else
                begin
                    op.rs    = 1'b1;
                    op.value = rows_reg[row_idx*8 +: 8];
                    if (step_reg == 4'd8)
                    begin
                        op.extra = lcd4_pkg::EXTRA_FIXED;
                        op.last  = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        type_next  = type_reg;
        byte_next  = byte_reg;
        addr_next  = addr_reg;
        slot_next  = slot_reg;
        rows_next  = rows_reg;
        push       = 1'b0;
        unique case (state_reg)
            lcd4_pkg::FRONT_IDLE:
            begin
                if (start && accept)
                begin
                    type_next = req_type;
                    byte_next = byte_value;
                    addr_next = lcd4_pkg::row_base(row[1:0] - 2'd1)
                                + {3'b000, column} - 8'd1;
                    slot_next = glyph_slot;
                    rows_next = glyph_rows;
                    step_next = '0;
                    if (req_type <= lcd4_pkg::REQ_GLYPH)
                    begin
                        state_next = lcd4_pkg::FRONT_EXPAND;
                    end
                end
            end
            default:
            begin
                if (!q_full)
                begin
                    push = 1'b1;
                    if (op.last)
                    begin
                        state_next = lcd4_pkg::FRONT_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
        endcase
    end

    assign active = (state_reg == lcd4_pkg::FRONT_EXPAND);

endmodule

[hdl/lcd4_queue.sv]
`timescale 1ns / 1ps

module lcd4_queue #(
    parameter int DEPTH = lcd4_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lcd4_pkg::byte_op_t push_op,
    input  logic               pop,
    output lcd4_pkg::byte_op_t head,
    output logic               full,
    output logic               not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(DEPTH);

    lcd4_pkg::byte_op_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hdl/lcd4_back.sv]
`timescale 1ns / 1ps

module lcd4_back #(
    parameter int HOLD_BITS = lcd4_pkg::HOLD_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lcd4_pkg::cfg_t                 cfg,
    input  logic                           q_not_empty,
    input  lcd4_pkg::byte_op_t             q_head,
    output logic                           pop,
    output logic                           active,
    output logic                           strobe,
    output logic                           reg_select,
    output logic                           read_write,
    output logic                           enable,
    output logic [3:0]                     nibble,
    output logic [lcd4_pkg::US_W-1:0]      hold_us,
    output logic                           last
);

    localparam logic [32:0] HOLD_MAX = (33'd1 << HOLD_BITS) - 33'd1;

    lcd4_pkg::byte_op_t op_reg, op_next;
    logic [1:0] phase_reg, phase_next;
    logic       active_reg, active_next;

    logic       strobe_reg, strobe_next;
    logic       rs_reg, rs_next;
    logic       en_reg, en_next;
    logic [3:0] nib_reg, nib_next;
    logic [lcd4_pkg::US_W-1:0] hold_reg, hold_next;
    logic       last_reg, last_next;

    logic [lcd4_pkg::SUM_W-1:0] extra_us;
    logic [lcd4_pkg::SUM_W-1:0] raw_hold;
    logic                       op_done;

    always_comb
    begin
        unique case (op_reg.extra)
            lcd4_pkg::EXTRA_CURSOR:    extra_us = {1'b0, cfg.cursor_wait};
            lcd4_pkg::EXTRA_COMMAND:   extra_us = {1'b0, cfg.command_wait};
            lcd4_pkg::EXTRA_CLEAR:     extra_us = {1'b0, cfg.clear_wait};
            lcd4_pkg::EXTRA_CMD_FIXED: extra_us = {1'b0, cfg.command_wait}
                                                  + {1'b0, lcd4_pkg::FIXED_WAIT_US};
            lcd4_pkg::EXTRA_FIXED:     extra_us = {1'b0, lcd4_pkg::FIXED_WAIT_US};
            default:                   extra_us = '0;
        endcase
    end

    always_comb
    begin
        rs_next  = op_reg.rs;
        en_next  = 1'b0;
        nib_next = op_reg.value[7:4];
        raw_hold = '0;
        op_done  = 1'b0;
        if (op_reg.startup)
        begin
            rs_next  = 1'b0;
            nib_next = 4'd0;
            raw_hold = {1'b0, cfg.startup_wait};
            op_done  = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                lcd4_pkg::PH_HIGH_EN:
                begin
                    en_next  = 1'b1;
                    raw_hold = {1'b0, cfg.enable_pulse};
                end
                lcd4_pkg::PH_HIGH_LOW:
                begin
                    raw_hold = op_reg.rs ? '0 : {1'b0, cfg.nibble_gap};
                end
                lcd4_pkg::PH_LOW_EN:
                begin
                    en_next  = 1'b1;
                    nib_next = op_reg.value[3:0];
                    raw_hold = {1'b0, cfg.enable_pulse};
                end
                default:
                begin
                    nib_next = op_reg.value[3:0];
                    raw_hold = extra_us;
                    op_done  = 1'b1;
                end
            endcase
        end
        if ({12'd0, raw_hold} > HOLD_MAX)
        begin
            hold_next = HOLD_MAX[lcd4_pkg::US_W-1:0];
        end
        else
        begin
            hold_next = raw_hold[lcd4_pkg::US_W-1:0];
        end
        last_next = op_done && op_reg.last;
    end

    always_comb
    begin
        op_next     = op_reg;
        phase_next  = phase_reg;
        active_next = active_reg;
        pop         = 1'b0;
        strobe_next = active_reg;
        if (!active_reg || op_done)
        begin
            if (q_not_empty)
            begin
                pop         = 1'b1;
                op_next     = q_head;
                phase_next  = lcd4_pkg::PH_HIGH_EN;
                active_next = 1'b1;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else
        begin
            phase_next = phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= lcd4_pkg::PH_HIGH_EN;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rs_reg   <= rs_next;
        en_reg   <= en_next;
        nib_reg  <= nib_next;
        hold_reg <= hold_next;
        last_reg <= last_next;
    end

    assign active     = active_reg;
    assign strobe     = strobe_reg;
    assign reg_select = rs_reg;
    assign read_write = 1'b0;
    assign enable     = en_reg;
    assign nibble     = nib_reg;
    assign hold_us    = hold_reg;
    assign last       = last_reg;

endmodule

[hdl/char_lcd_4bit_write_sequencer.sv]
`timescale 1ns / 1ps

// Character LCD write sequencer for a 4-bit parallel bus.
// Request channel: an item is taken when start is high and busy is low.
// req_type selects command, data, go to position, clear, init or glyph load.
// Each byte of a request comes out as four pin phases: EN high with the high
// nibble, EN low, EN high with the low nibble, EN low. Init opens with a single
// power wait phase. Each phase carries RS, RW, EN, D7..D4 and a hold time.
// Result channel: one phase per cycle on strobe; the receiver cannot stall,
// so the phase is taken at the edge that ends its strobe cycle. last marks the
// final phase of a request.
// The front end registers a request and splits it into byte ops, which the
// queue hands to the back end; that registers one phase per cycle on strobe:
// 4 for a command or data byte, 25 for init, 36 for a glyph. busy stays high
// until the last phase is registered; unknown request types give no phases.
// Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data
// (wait times in microseconds); cfg_ready is always high, indexes past the
// last register are dropped. Write only while busy is low.
// Reset: all waits return to their defaults and any item in flight is dropped.

module char_lcd_4bit_write_sequencer #(
    parameter int HOLD_BITS   = lcd4_pkg::HOLD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 req_type,
    input  logic [7:0]                 byte_value,
    input  logic [4:0]                 column,
    input  logic [2:0]                 row,
    input  logic [2:0]                 glyph_slot,
    input  logic [63:0]                glyph_rows,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [lcd4_pkg::US_W-1:0]  cfg_data,
    output logic                       strobe,
    output logic                       reg_select,
    output logic                       read_write,
    output logic                       enable,
    output logic [3:0]                 nibble,
    output logic [lcd4_pkg::US_W-1:0]  hold_us,
    output logic                       last
);

    lcd4_pkg::cfg_t     cfg_reg, cfg_next;
    lcd4_pkg::byte_op_t push_op, head_op;
    logic push, pop, q_full, q_not_empty, front_active, back_active;

    assign cfg_ready = 1'b1;
    assign busy      = front_active || q_not_empty || back_active;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lcd4_pkg::CFG_ENABLE_PULSE: cfg_next.enable_pulse = cfg_data;
                lcd4_pkg::CFG_NIBBLE_GAP:   cfg_next.nibble_gap   = cfg_data;
                lcd4_pkg::CFG_CURSOR_WAIT:  cfg_next.cursor_wait  = cfg_data;
                lcd4_pkg::CFG_COMMAND_WAIT: cfg_next.command_wait = cfg_data;
                lcd4_pkg::CFG_CLEAR_WAIT:   cfg_next.clear_wait   = cfg_data;
                lcd4_pkg::CFG_STARTUP_WAIT: cfg_next.startup_wait = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse <= 20'd25;
            cfg_reg.nibble_gap   <= 20'd25;
            cfg_reg.cursor_wait  <= 20'd100;
            cfg_reg.command_wait <= 20'd45;
            cfg_reg.clear_wait   <= 20'd3000;
            cfg_reg.startup_wait <= 20'd100000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcd4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .accept     (!busy),
        .req_type   (req_type),
        .byte_value (byte_value),
        .column     (column),
        .row        (row),
        .glyph_slot (glyph_slot),
        .glyph_rows (glyph_rows),
        .q_full     (q_full),
        .push       (push),
        .op         (push_op),
        .active     (front_active)
    );

    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .head      (head_op),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    lcd4_back #(
        .HOLD_BITS (HOLD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head_op),
        .pop         (pop),
        .active      (back_active),
        .strobe      (strobe),
        .reg_select  (reg_select),
        .read_write  (read_write),
        .enable      (enable),
        .nibble      (nibble),
        .hold_us     (hold_us),
        .last        (last)
    );

endmodule
